// ===== hdl/dictionary_token_expander_unit_defines.svh =====
// Assertion macros shared by the dictionary token expander RTL.
// Included by the top level; depends on nothing else.
`ifndef DICTIONARY_TOKEN_EXPANDER_UNIT_DEFINES_SVH
`define DICTIONARY_TOKEN_EXPANDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DTE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dte: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dte: next-cycle check failed");

`endif

// ===== hdl/dte_pkg.sv =====
// Shared types and constants for the dictionary token expander.
// No dependencies.
package dte_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 32;
  localparam int MAX_TOKENS_DEF    = 254;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [7:0] TOKEN_COUNT_RESET = 8'd254;
  localparam logic [7:0] ESC_BYTE          = 8'hFF;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Commands passed from front to back
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_LIT   = 2'd1;
  localparam logic [1:0] CMD_ERR   = 2'd2;
  localparam logic [1:0] CMD_TOKEN = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;   // literal byte, load character, or token index
    logic [7:0] idx;    // load slot
    logic [4:0] pos;    // load position
    logic       tend;   // load sets length
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/dictionary_token_expander_unit.sv =====
// Dictionary token expander. Takes one item per cycle while its two-entry command queue
// has room. The back end completes each load, literal or error result in the cycle that
// pops it. For a token index it pops the index while reading the token length, latches the
// length and issues the first byte read, then emits the token bytes at one per cycle while
// out_stall is low. The byte memory's single read port sets that rate, and the queue lets
// new items arrive meanwhile. No clearing pass: loaded-slot flags are flip-flops cleared by
// reset. Results wait in an output register. While out_stall is high the back end stops at
// its next result, the queue fills behind it, and then in_stall rises. Depends on dte_pkg,
// dte_front, dte_queue, dte_back and the assertion macro header.
`include "dictionary_token_expander_unit_defines.svh"

module dictionary_token_expander_unit #(
  parameter int MAX_TOKEN_LEN = dte_pkg::MAX_TOKEN_LEN_DEF,
  parameter int MAX_TOKENS    = dte_pkg::MAX_TOKENS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  input  logic [7:0] token_index,
  input  logic [4:0] char_position,
  input  logic       token_end,
  input  logic       value_end,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       error
);
  import dte_pkg::*;

  logic    q_push;
  logic    q_pop;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  q_stat_t q_stat;

  dte_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .MAX_TOKENS   (MAX_TOKENS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .token_index   (token_index),
    .char_position (char_position),
    .token_end     (token_end),
    .value_end     (value_end),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_stat        (q_stat),
    .push          (q_push),
    .push_cmd      (push_cmd)
  );

  dte_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  dte_back #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .MAX_TOKENS   (MAX_TOKENS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .head_cmd    (head_cmd),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .error       (error)
  );

  `DTE_ASSERT_IMPLY(a_err_result, clk, rst, out_valid && error, out_byte == 8'h00 && last_of_run)
  `DTE_ASSERT_IMPLY(a_no_overflow, clk, rst, q_push, !q_stat.full)
  `DTE_ASSERT_IMPLY(a_no_underflow, clk, rst, q_pop, !q_stat.empty)
  `DTE_ASSERT_NEXT(a_push_lands, clk, rst, q_push && !q_pop, !q_stat.empty)

endmodule

// ===== hdl/dte_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dte_front.sv =====
// Front end: accepts items, tracks escape state and loaded slots, issues commands.
// Depends on dte_pkg.
module dte_front #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int MAX_TOKENS    = 254
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            opcode,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      token_index,
  input  logic [4:0]      char_position,
  input  logic            token_end,
  input  logic            value_end,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data,
  input  dte_pkg::q_stat_t q_stat,
  output logic            push,
  output dte_pkg::cmd_t   push_cmd
);
  import dte_pkg::*;

  localparam int TIW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

  logic                  esc_pending;
  logic                  esc_pending_next;
  logic [7:0]            token_count;
  logic [MAX_TOKENS-1:0] loaded;
  logic                  accept;
  logic                  ld_ok;
  logic                  tok_ok;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  assign ld_ok  = (token_index < 8'(MAX_TOKENS)) &&
                  ({2'b00, char_position} < 7'(MAX_TOKEN_LEN));
  // slot validity is known here since loads pass in order
  assign tok_ok = (data_byte < token_count) && (data_byte < 8'(MAX_TOKENS)) &&
                  loaded[data_byte[TIW-1:0]];

  always_comb begin
    push_cmd.kind    = CMD_LIT;
    push_cmd.data    = data_byte;
    push_cmd.idx     = token_index;
    push_cmd.pos     = char_position;
    push_cmd.tend    = token_end;
    push             = 1'b0;
    esc_pending_next = esc_pending;
    if (accept) begin
      if (opcode == OP_LOAD) begin
        if (ld_ok) begin
          push          = 1'b1;
          push_cmd.kind = CMD_LOAD;
        end
      end else if (esc_pending) begin
        esc_pending_next = 1'b0;
        push             = 1'b1;
        if (data_byte == ESC_BYTE) begin
          push_cmd.kind = CMD_LIT;
        end else if (tok_ok) begin
          push_cmd.kind = CMD_TOKEN;
        end else begin
          push_cmd.kind = CMD_ERR;
          push_cmd.data = 8'h00;
        end
      end else if (data_byte == ESC_BYTE) begin
        if (value_end) begin
          push          = 1'b1;
          push_cmd.kind = CMD_ERR;
          push_cmd.data = 8'h00;
        end else begin
          esc_pending_next = 1'b1;
        end
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_pending <= 1'b0;
      token_count <= TOKEN_COUNT_RESET;
      loaded      <= '0;
    end else begin
      esc_pending <= esc_pending_next;
      if (cfg_wr_en) begin
        token_count <= cfg_wr_data;
      end
      if (accept && opcode == OP_LOAD && ld_ok && token_end) begin
        loaded[token_index[TIW-1:0]] <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dte_queue.sv =====
// Short command queue between front and back ends.
// Depends on dte_pkg.
module dte_queue #(
  parameter int DEPTH = dte_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dte_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output dte_pkg::cmd_t    head_cmd,
  output dte_pkg::q_stat_t q_stat
);
  import dte_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head_cmd     = entries[rd_ptr];
  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dte_back.sv =====
// Back end: executes commands, owns the token byte and length memories, drives results.
// Depends on dte_pkg and dte_ram.
module dte_back #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int MAX_TOKENS    = 254
) (
  input  logic             clk,
  input  logic             rst,
  input  dte_pkg::q_stat_t q_stat,
  input  dte_pkg::cmd_t    head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             error
);
  import dte_pkg::*;

  localparam int TIW    = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int BDEPTH = MAX_TOKENS * MAX_TOKEN_LEN;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int LW     = $clog2(MAX_TOKEN_LEN + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]     state;
  logic           data_ok;     // byte RAM output holds an unsent byte
  logic [BAW-1:0] rd_addr;
  logic [LW-1:0]  issue_left;
  logic [LW-1:0]  emit_left;

  logic           out_free;
  logic           idle_go;
  logic           take;
  logic           issue;
  logic           load_out_cmd;
  logic           do_load;
  logic           is_token;
  logic [TIW-1:0] slot;
  logic [BAW-1:0] base;
  logic [BAW-1:0] head_addr;
  logic [7:0]     byte_q;
  logic [LW-1:0]  len_q;
  logic [LW-1:0]  len_wdata;

  assign out_free = !out_valid || !out_stall;
  assign idle_go  = (state == ST_IDLE) && !q_stat.empty;
  assign take     = (state == ST_RUN) && data_ok && out_free;
  assign issue    = (state == ST_RUN) && (issue_left != '0) && (!data_ok || take);

  assign slot      = head_cmd.idx[TIW-1:0];
  assign base      = BAW'(head_cmd.data[TIW-1:0]) * BAW'(MAX_TOKEN_LEN);
  assign head_addr = BAW'(slot) * BAW'(MAX_TOKEN_LEN) + BAW'(head_cmd.pos);
  assign len_wdata = LW'({1'b0, head_cmd.pos} + 6'd1);

  always_comb begin
    pop          = 1'b0;
    load_out_cmd = 1'b0;
    do_load      = 1'b0;
    is_token     = 1'b0;
    if (idle_go) begin
      case (head_cmd.kind)
        CMD_LOAD: begin
          pop     = 1'b1;
          do_load = 1'b1;
        end
        CMD_TOKEN: begin
          pop      = 1'b1;
          is_token = 1'b1;
        end
        CMD_LIT, CMD_ERR: begin
          pop          = out_free;
          load_out_cmd = out_free;
        end
        default: begin
          pop = 1'b0;
        end
      endcase
    end
  end

  dte_ram #(
    .WIDTH(8),
    .DEPTH(BDEPTH)
  ) u_bytes (
    .clk   (clk),
    .we    (do_load),
    .waddr (head_addr),
    .wdata (head_cmd.data),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (byte_q)
  );

  dte_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_TOKENS)
  ) u_lengths (
    .clk   (clk),
    .we    (do_load && head_cmd.tend),
    .waddr (slot),
    .wdata (len_wdata),
    .re    (is_token),
    .raddr (head_cmd.data[TIW-1:0]),
    .rdata (len_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      data_ok   <= 1'b0;
    end else begin
      if (load_out_cmd || take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (issue) begin
        data_ok <= 1'b1;
      end else if (take) begin
        data_ok <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (is_token) begin
            state <= ST_LEN;
          end
        end
        ST_LEN: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (take && emit_left == LW'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_cmd) begin
      out_byte    <= head_cmd.data;
      last_of_run <= 1'b1;
      error       <= (head_cmd.kind == CMD_ERR);
    end else if (take) begin
      out_byte    <= byte_q;
      last_of_run <= (emit_left == LW'(1));
      error       <= 1'b0;
    end
    if (is_token) begin
      rd_addr <= base;
    end else if (issue) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (state == ST_LEN) begin
      issue_left <= len_q;
      emit_left  <= len_q;
    end else begin
      if (issue) begin
        issue_left <= issue_left - 1'b1;
      end
      if (take) begin
        emit_left <= emit_left - 1'b1;
      end
    end
  end

endmodule

// ===== verif/dictionary_token_expander_unit_checker.sv =====
// Checker for the dictionary token expander: watches the input, output and config ports,
// keeps its own copy of the dictionary and escape state, and compares every output byte.
// Depends on dte_pkg.
module dictionary_token_expander_unit_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  input  logic [7:0] token_index,
  input  logic [4:0] char_position,
  input  logic       token_end,
  input  logic       value_end,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       last_of_run,
  input  logic       error,
  output int         pending,
  output int         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import dte_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } expanded_byte_t;

  logic [7:0]     dict_chars [MAX_TOKENS_DEF][MAX_TOKEN_LEN_DEF];
  logic [5:0]     dict_len [MAX_TOKENS_DEF];
  logic           escape_armed;
  logic [7:0]     tokens_in_use;
  expanded_byte_t due_bytes [$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  task automatic report_mismatch(input string what);
    $display("checker: %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic emit(input logic [7:0] d, input logic l, input logic e);
    due_bytes.push_back({d, l, e});
  endtask

  task automatic expand_transaction(input logic op, input logic [7:0] b,
                                    input logic [7:0] slot, input logic [4:0] pos,
                                    input logic tend, input logic vend);
    int n;
    if (op == OP_LOAD) begin
      if (slot < MAX_TOKENS_DEF && pos < MAX_TOKEN_LEN_DEF) begin
        dict_chars[slot][pos] = b;
        if (tend) dict_len[slot] = 6'(pos + 6'd1);
      end
    end else if (escape_armed) begin
      escape_armed = 1'b0;
      if (b == ESC_BYTE) begin
        emit(ESC_BYTE, 1'b1, 1'b0);
      end else if (b >= tokens_in_use || b >= MAX_TOKENS_DEF || dict_len[b] == 6'd0) begin
        emit(8'h00, 1'b1, 1'b1);
      end else begin
        n = dict_len[b];
        for (int i = 0; i < n; i++) emit(dict_chars[b][i], (i == n - 1), 1'b0);
      end
    end else if (b == ESC_BYTE) begin
      // escape with nothing after it in the value
      if (vend) emit(8'h00, 1'b1, 1'b1);
      else escape_armed = 1'b1;
    end else begin
      emit(b, 1'b1, 1'b0);
    end
  endtask

  always @(posedge clk) begin : watch
    expanded_byte_t want;
    if (rst) begin
      foreach (dict_len[i]) dict_len[i] = '0;
      escape_armed  = 1'b0;
      tokens_in_use = TOKEN_COUNT_RESET;
      due_bytes.delete();
    end else begin
      // a transaction on the same edge as a config write still sees the old count
      if (in_valid && !in_stall)
        expand_transaction(opcode, data_byte, token_index, char_position, token_end, value_end);
      if (cfg_wr_en) tokens_in_use = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (due_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h last %0b error %0b",
                                    out_byte, last_of_run, error));
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run, want.last));
          if (error !== want.err)
            report_mismatch($sformatf("error %0b, want %0b", error, want.err));
        end
      end
    end
    pending = due_bytes.size();
  end

endmodule

// ===== verif/dictionary_token_expander_unit_test.sv =====
// Testbench top for the dictionary token expander: clock, reset, stimulus and verdict.
// Depends on dte_pkg, dictionary_token_expander_unit and its checker module.
module dictionary_token_expander_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dte_pkg::*;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       opcode;
  logic [7:0] data_byte;
  logic [7:0] token_index;
  logic [4:0] char_position;
  logic       token_end;
  logic       value_end;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       error;
  int         pending;
  int         fail_count;

  bit          calm_tail;
  int          sent;
  logic [31:0] chars_written [256];

  dictionary_token_expander_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .data_byte(data_byte), .token_index(token_index),
    .char_position(char_position), .token_end(token_end), .value_end(value_end),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .last_of_run(last_of_run), .error(error)
  );

  dictionary_token_expander_unit_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .data_byte(data_byte), .token_index(token_index),
    .char_position(char_position), .token_end(token_end), .value_end(value_end),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .last_of_run(last_of_run), .error(error),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dictionary_token_expander_unit_test: done, errors");
    $finish;
  end

  // receiver back-pressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic drive_item(input logic op, input logic [7:0] b, input logic [7:0] slot,
                            input logic [4:0] pos, input logic tend, input logic vend);
    logic [31:0] need;
    need = 32'((33'd1 << (pos + 6'd1)) - 33'd1);
    // a token may only be closed once all of its characters have been written
    if (op == OP_LOAD && slot < MAX_TOKENS_DEF) begin
      chars_written[slot][pos] = 1'b1;
      if ((chars_written[slot] & need) != need) tend = 1'b0;
    end
    in_valid      = 1'b1;
    opcode        = op;
    data_byte     = b;
    token_index   = slot;
    char_position = pos;
    token_end     = tend;
    value_end     = vend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic vend);
    drive_item(OP_DECODE, b, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
               1'($urandom_range(0, 1)), vend);
  endtask

  task automatic load_token(input logic [7:0] slot, input int len);
    for (int p = 0; p < len; p++)
      drive_item(OP_LOAD, 8'($urandom_range(0, 255)), slot, 5'(p), (p == len - 1),
                 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [7:0] pick_slot();
    case ($urandom_range(0, 5))
      0:       return 8'd253;
      1:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 7));
    endcase
  endfunction

  // drain everything, then allow the back end to finish any trailing loads
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_token_count(input logic [7:0] v);
    settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic random_traffic(input int target);
    int         stop;
    logic [7:0] slot;
    stop = sent + target;
    while (sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          slot = pick_slot();
          load_token(slot, ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 6));
        end
        2, 3, 4: decode_byte(8'($urandom_range(0, 254)), 1'($urandom_range(0, 1)));
        5, 6: begin
          decode_byte(ESC_BYTE, 1'b0);
          decode_byte(pick_slot(), 1'($urandom_range(0, 1)));
        end
        7: begin
          decode_byte(ESC_BYTE, 1'b0);
          decode_byte(ESC_BYTE, 1'($urandom_range(0, 1)));
        end
        8: decode_byte(ESC_BYTE, 1'($urandom_range(0, 1)));
        default: drive_item(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    opcode        = OP_LOAD;
    data_byte     = '0;
    token_index   = '0;
    char_position = '0;
    token_end     = 1'b0;
    value_end     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    calm_tail     = 1'b0;
    sent          = 0;
    foreach (chars_written[i]) chars_written[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_token_count(8'd254);
    // short tokens in slots 0 and 1, and a load to a slot that does not exist
    drive_item(OP_LOAD, 8'h00, 8'd0, 5'd0, 1'b1, 1'b0);
    drive_item(OP_LOAD, 8'hFF, 8'd1, 5'd0, 1'b0, 1'b0);
    drive_item(OP_LOAD, 8'h00, 8'd1, 5'd1, 1'b0, 1'b1);
    drive_item(OP_LOAD, 8'h80, 8'd1, 5'd2, 1'b1, 1'b0);
    drive_item(OP_LOAD, 8'hAA, 8'hFF, 5'd31, 1'b1, 1'b1);
    decode_byte(8'h00, 1'b0);
    decode_byte(8'hFE, 1'b1);
    decode_byte(ESC_BYTE, 1'b0);
    decode_byte(ESC_BYTE, 1'b1);
    decode_byte(ESC_BYTE, 1'b0);
    decode_byte(8'd0, 1'b0);
    // a load between escape and index leaves the escape armed
    decode_byte(ESC_BYTE, 1'b0);
    drive_item(OP_LOAD, 8'h5A, 8'd2, 5'd0, 1'b0, 1'b0);
    decode_byte(8'd1, 1'b1);
    decode_byte(ESC_BYTE, 1'b0);
    decode_byte(8'd5, 1'b0);
    decode_byte(ESC_BYTE, 1'b0);
    decode_byte(8'd254, 1'b0);
    decode_byte(ESC_BYTE, 1'b0);
    decode_byte(8'd253, 1'b0);
    decode_byte(ESC_BYTE, 1'b1);
    decode_byte(ESC_BYTE, 1'b0);
    decode_byte(8'h41, 1'b1);

    // longest token in the last slot
    load_token(8'd253, 32);
    decode_byte(ESC_BYTE, 1'b0);
    decode_byte(8'd253, 1'b1);
    random_traffic(20);

    set_token_count(8'd1);
    random_traffic(15);
    set_token_count(8'd0);
    random_traffic(10);
    set_token_count(8'd255);
    random_traffic(15);
    set_token_count(8'($urandom_range(1, 254)));
    random_traffic(20);
    set_token_count(8'd254);
    calm_tail = 1'b1;
    random_traffic(20);

    settle();
    if (fail_count == 0)
      $display("dictionary_token_expander_unit_test: done, clean");
    else
      $display("dictionary_token_expander_unit_test: done, errors");
    $finish;
  end

endmodule
